[hw/rtl/i2c_memory_transaction_sequencer_macros.svh]
// Assertion macros shared by the memory transaction sequencer RTL.
`ifndef I2C_MEMORY_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MEMORY_TRANSACTION_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define I2CMTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cmts: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define I2CMTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cmts: next-cycle check failed");
`else
`define I2CMTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define I2CMTS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/i2cmts_pkg.sv]
// Types and constants of the I2C memory transaction sequencer.
package i2cmts_pkg;

    // Beat kinds on the input channel.
    typedef enum logic [1:0] {
        MODE_CMD     = 2'd0,
        MODE_STATUS  = 2'd1,
        MODE_PAYLOAD = 2'd2
    } t_mode;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_SLAW   = 4'd2,
        PH_ADDRH  = 4'd3,
        PH_ADDRL  = 4'd4,
        PH_RSTART = 4'd5,
        PH_SLAR   = 4'd6,
        PH_READ   = 4'd7,
        PH_WNEED  = 4'd8,
        PH_WRITE  = 4'd9
    } t_phase;

    // Requests to the bus engine.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RDACK = 3'd3,
        ACT_RDNAK = 3'd4,
        ACT_STOP  = 3'd5,
        ACT_REQ   = 3'd6
    } t_action;

    // Transaction outcome reported with stop.
    typedef enum logic [1:0] {
        OUT_OK     = 2'd0,
        OUT_BUSERR = 2'd1,
        OUT_NODEV  = 2'd2,
        OUT_BUSY   = 2'd3
    } t_outcome;

    // Bus engine status codes.
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;

    // One result beat.
    typedef struct packed {
        t_action    action;
        logic [7:0] send_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        t_outcome   outcome;
    } t_result;

endpackage

[hw/rtl/i2cmts_core.sv]
// Transaction phase machine: holds the command and produces one result per beat.
`include "i2c_memory_transaction_sequencer_macros.svh"

module i2cmts_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [1:0]          i_mode,
    input  logic [6:0]          i_dev_addr,
    input  logic                i_is_read,
    input  logic                i_addr_two_bytes,
    input  logic [15:0]         i_mem_addr,
    input  logic [15:0]         i_byte_count,
    input  logic [7:0]          i_bus_status,
    input  logic [7:0]          i_bus_byte,
    input  logic [7:0]          i_write_byte,
    output i2cmts_pkg::t_result o_result
);

    i2cmts_pkg::t_phase r_phase, n_phase;
    logic [6:0]         r_dev, n_dev;
    logic               r_rd, n_rd;
    logic               r_wide, n_wide;
    logic [15:0]        r_maddr, n_maddr;
    logic [15:0]        r_total, n_total;
    logic [15:0]        r_cnt, n_cnt;
    i2cmts_pkg::t_result res;

    logic [16:0] cnt_p1;
    logic [16:0] cnt_p2;
    logic [16:0] total_x;

    // Ends the transaction with stop and the given outcome.
    function automatic i2cmts_pkg::t_result f_finish(input i2cmts_pkg::t_outcome oc);
        i2cmts_pkg::t_result r;
        r           = '0;
        r.action    = i2cmts_pkg::ACT_STOP;
        r.done_res  = 1'b1;
        r.outcome   = oc;
        return r;
    endfunction

    // Requests the next byte to be sent.
    function automatic i2cmts_pkg::t_result f_send(input logic [7:0] b);
        i2cmts_pkg::t_result r;
        r           = '0;
        r.action    = i2cmts_pkg::ACT_SEND;
        r.send_byte = b;
        return r;
    endfunction

    assign cnt_p1  = {1'b0, r_cnt} + 17'd1;
    assign cnt_p2  = {1'b0, r_cnt} + 17'd2;
    assign total_x = {1'b0, r_total};

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cmts_pkg::PH_IDLE;
            r_dev   <= '0;
            r_rd    <= 1'b0;
            r_wide  <= 1'b0;
            r_maddr <= '0;
            r_total <= '0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_dev   <= n_dev;
            r_rd    <= n_rd;
            r_wide  <= n_wide;
            r_maddr <= n_maddr;
            r_total <= n_total;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and result for the beat at the input.
    always_comb begin
        n_phase = r_phase;
        n_dev   = r_dev;
        n_rd    = r_rd;
        n_wide  = r_wide;
        n_maddr = r_maddr;
        n_total = r_total;
        n_cnt   = r_cnt;
        res     = '0;
        case (i_mode)
            i2cmts_pkg::MODE_CMD: begin
                if (r_phase == i2cmts_pkg::PH_IDLE) begin
                    n_dev      = i_dev_addr;
                    n_rd       = i_is_read;
                    n_wide     = i_addr_two_bytes;
                    n_maddr    = i_mem_addr;
                    // A zero count is taken as a single byte.
                    n_total    = (i_byte_count == 16'd0) ? 16'd1 : i_byte_count;
                    n_cnt      = '0;
                    res.action = i2cmts_pkg::ACT_START;
                    n_phase    = i2cmts_pkg::PH_START;
                end
            end
            i2cmts_pkg::MODE_STATUS: begin
                case (r_phase)
                    i2cmts_pkg::PH_START: begin
                        if (i_bus_status == i2cmts_pkg::ST_START) begin
                            res     = f_send({r_dev, 1'b0});
                            n_phase = i2cmts_pkg::PH_SLAW;
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSERR);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_SLAW: begin
                        if (i_bus_status == i2cmts_pkg::ST_SLAW_ACK) begin
                            if (r_wide) begin
                                res     = f_send(r_maddr[15:8]);
                                n_phase = i2cmts_pkg::PH_ADDRH;
                            end else begin
                                res     = f_send(r_maddr[7:0]);
                                n_phase = i2cmts_pkg::PH_ADDRL;
                            end
                        end else if (i_bus_status == i2cmts_pkg::ST_SLAW_NACK) begin
                            res     = f_finish(i2cmts_pkg::OUT_NODEV);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSERR);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_ADDRH: begin
                        if (i_bus_status == i2cmts_pkg::ST_DATA_ACK) begin
                            res     = f_send(r_maddr[7:0]);
                            n_phase = i2cmts_pkg::PH_ADDRL;
                        end else if (i_bus_status == i2cmts_pkg::ST_DATA_NACK) begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSY);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSERR);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_ADDRL: begin
                        if (i_bus_status == i2cmts_pkg::ST_DATA_ACK) begin
                            if (r_rd) begin
                                res.action = i2cmts_pkg::ACT_START;
                                n_phase    = i2cmts_pkg::PH_RSTART;
                            end else begin
                                res.action = i2cmts_pkg::ACT_REQ;
                                n_phase    = i2cmts_pkg::PH_WNEED;
                            end
                        end else if (i_bus_status == i2cmts_pkg::ST_DATA_NACK) begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSY);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSERR);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_RSTART: begin
                        if (i_bus_status == i2cmts_pkg::ST_REP_START) begin
                            res     = f_send({r_dev, 1'b1});
                            n_phase = i2cmts_pkg::PH_SLAR;
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSERR);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_SLAR: begin
                        if (i_bus_status == i2cmts_pkg::ST_SLAR_ACK) begin
                            // Every byte but the last is acknowledged.
                            res.action = (cnt_p1 < total_x) ? i2cmts_pkg::ACT_RDACK
                                                            : i2cmts_pkg::ACT_RDNAK;
                            n_phase    = i2cmts_pkg::PH_READ;
                        end else if (i_bus_status == i2cmts_pkg::ST_SLAR_NACK) begin
                            res     = f_finish(i2cmts_pkg::OUT_NODEV);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSERR);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_READ: begin
                        // The received byte is handed on without checking status.
                        n_cnt = cnt_p1[15:0];
                        if (cnt_p1 >= total_x) begin
                            res     = f_finish(i2cmts_pkg::OUT_OK);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end else begin
                            res.action = (cnt_p2 < total_x) ? i2cmts_pkg::ACT_RDACK
                                                            : i2cmts_pkg::ACT_RDNAK;
                        end
                        res.read_valid = 1'b1;
                        res.read_data  = i_bus_byte;
                    end
                    i2cmts_pkg::PH_WRITE: begin
                        if (i_bus_status == i2cmts_pkg::ST_DATA_ACK) begin
                            n_cnt = cnt_p1[15:0];
                            if (cnt_p1 >= total_x) begin
                                res     = f_finish(i2cmts_pkg::OUT_OK);
                                n_phase = i2cmts_pkg::PH_IDLE;
                            end else begin
                                res.action = i2cmts_pkg::ACT_REQ;
                                n_phase    = i2cmts_pkg::PH_WNEED;
                            end
                        end else begin
                            res     = f_finish(i2cmts_pkg::OUT_BUSY);
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        // Status while idle or awaiting a payload byte is ignored.
                        res = '0;
                    end
                endcase
            end
            i2cmts_pkg::MODE_PAYLOAD: begin
                if (r_phase == i2cmts_pkg::PH_WNEED) begin
                    res     = f_send(i_write_byte);
                    n_phase = i2cmts_pkg::PH_WRITE;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign o_result = res;

    // A running transaction always has a nonzero byte total.
    `I2CMTS_ASSERT_IMP(a_total_nonzero, i_clk, i_rst_n,
        r_phase != i2cmts_pkg::PH_IDLE, r_total != 16'd0)
    // The payload counter stays below the total while payload moves.
    `I2CMTS_ASSERT_IMP(a_cnt_below_total, i_clk, i_rst_n,
        r_phase == i2cmts_pkg::PH_READ || r_phase == i2cmts_pkg::PH_WNEED ||
        r_phase == i2cmts_pkg::PH_WRITE, r_cnt < r_total)
    // A command taken while idle starts a fresh transaction.
    `I2CMTS_ASSERT_NXT(a_cmd_starts, i_clk, i_rst_n,
        i_step && i_mode == i2cmts_pkg::MODE_CMD && r_phase == i2cmts_pkg::PH_IDLE,
        r_phase == i2cmts_pkg::PH_START && r_cnt == 16'd0)

endmodule

[hw/rtl/i2c_memory_transaction_sequencer.sv]
// Top level of the I2C memory transaction sequencer with its result register.
//
// Usage: the input channel carries one beat per event: a new command (device
// address, direction, one- or two-byte memory address, byte count), a status
// event from the bus engine (status code and received byte), or the next
// payload byte for a write. Every accepted beat yields exactly one result
// beat: the next bus action, a byte to send, a received payload byte and, on
// stop, the done flag with the transaction outcome.
// The result of a beat accepted at an edge is registered and offered at the
// output in the next cycle. Throughput is one beat per cycle while the
// receiver takes results; the transaction state and the output register are
// both updated at the accept edge.
// The result register frees its slot in the same cycle it is taken, so input
// is accepted whenever the register is empty or is being drained. When the
// receiver stalls, the result is held and input ready drops until it is taken.
// Reset clears the phase to idle, the stored command to zero and drops the
// output valid.
`include "i2c_memory_transaction_sequencer_macros.svh"

module i2c_memory_transaction_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_dev_addr,
    input  logic        i_is_read,
    input  logic        i_addr_two_bytes,
    input  logic [15:0] i_mem_addr,
    input  logic [15:0] i_byte_count,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_bus_byte,
    input  logic [7:0]  i_write_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_send_byte,
    output logic        o_read_valid,
    output logic [7:0]  o_read_data,
    output logic        o_done_res,
    output logic [1:0]  o_outcome
);

    logic                in_beat;
    i2cmts_pkg::t_result step_res;
    i2cmts_pkg::t_result r_out;
    logic                r_out_valid, n_out_valid;

    // Input is taken when the result register is empty or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    i2cmts_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_beat),
        .i_mode           (i_mode),
        .i_dev_addr       (i_dev_addr),
        .i_is_read        (i_is_read),
        .i_addr_two_bytes (i_addr_two_bytes),
        .i_mem_addr       (i_mem_addr),
        .i_byte_count     (i_byte_count),
        .i_bus_status     (i_bus_status),
        .i_bus_byte       (i_bus_byte),
        .i_write_byte     (i_write_byte),
        .o_result         (step_res)
    );

    // Output valid follows accepted and drained beats.
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_beat) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_action     = r_out.action;
    assign o_send_byte  = r_out.send_byte;
    assign o_read_valid = r_out.read_valid;
    assign o_read_data  = r_out.read_data;
    assign o_done_res   = r_out.done_res;
    assign o_outcome    = r_out.outcome;

    // A finished transaction is always reported together with stop.
    `I2CMTS_ASSERT_IMP(a_done_is_stop, i_clk, i_rst_n,
        r_out_valid && r_out.done_res, r_out.action == i2cmts_pkg::ACT_STOP)
    // An outcome other than ok appears only with done.
    `I2CMTS_ASSERT_IMP(a_outcome_with_done, i_clk, i_rst_n,
        r_out_valid && r_out.outcome != i2cmts_pkg::OUT_OK, r_out.done_res)
    // Every accepted beat is offered at the output in the next cycle.
    `I2CMTS_ASSERT_NXT(a_beat_reaches_out, i_clk, i_rst_n,
        in_beat, r_out_valid)

endmodule

[dv/i2c_memory_transaction_sequencer_checker.sv]
// Result predictor and scoreboard for the I2C memory transaction sequencer.
`timescale 1ns / 1ps

module i2c_memory_transaction_sequencer_checker
    import i2cmts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_dev_addr,
    input  logic        i_is_read,
    input  logic        i_addr_two_bytes,
    input  logic [15:0] i_mem_addr,
    input  logic [15:0] i_byte_count,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_bus_byte,
    input  logic [7:0]  i_write_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_send_byte,
    input  logic        i_read_valid,
    input  logic [7:0]  i_read_data,
    input  logic        i_done_res,
    input  logic [1:0]  i_outcome,
    output int          o_error_count,
    output int          o_results_owed
);

    // Our own copy of the transaction state.
    t_phase      txn_phase;
    logic [6:0]  txn_dev;
    logic        txn_read;
    logic        txn_wide;
    logic [15:0] txn_mem_addr;
    logic [15:0] txn_total;
    logic [15:0] txn_done;

    // Results predicted for accepted input beats, oldest first.
    t_result     owed_results[$];
    int          mismatches = 0;
    int          owed_count = 0;
    int          results_seen = 0;

    assign o_error_count  = mismatches;
    assign o_results_owed = owed_count;

    // One line per mismatch, and the mismatch is counted.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR result %0d: %s is 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Stop the transaction and report how it ended.
    function automatic t_result stop_with(t_outcome code);
        t_result r;
        r          = '0;
        r.action   = ACT_STOP;
        r.done_res = 1'b1;
        r.outcome  = code;
        txn_phase  = PH_IDLE;
        return r;
    endfunction

    // Put a byte on the bus and move on.
    function automatic t_result send_then(logic [7:0] data, t_phase next);
        t_result r;
        r           = '0;
        r.action    = ACT_SEND;
        r.send_byte = data;
        txn_phase   = next;
        return r;
    endfunction

    // Every read is acked except the one for the last byte.
    function automatic t_result issue_read();
        t_result r;
        r         = '0;
        r.action  = ({1'b0, txn_done} + 17'd1 < {1'b0, txn_total}) ? ACT_RDACK : ACT_RDNAK;
        txn_phase = PH_READ;
        return r;
    endfunction

    // Reaction to a status code from the bus engine in the current phase.
    function automatic t_result on_bus_status(logic [7:0] st, logic [7:0] rx);
        t_result r;
        r = '0;
        case (txn_phase)
            PH_START: begin
                if (st == ST_START) r = send_then({txn_dev, 1'b0}, PH_SLAW);
                else r = stop_with(OUT_BUSERR);
            end
            PH_SLAW: begin
                if (st == ST_SLAW_ACK) begin
                    if (txn_wide) r = send_then(txn_mem_addr[15:8], PH_ADDRH);
                    else r = send_then(txn_mem_addr[7:0], PH_ADDRL);
                end else if (st == ST_SLAW_NACK) begin
                    r = stop_with(OUT_NODEV);
                end else begin
                    r = stop_with(OUT_BUSERR);
                end
            end
            PH_ADDRH: begin
                if (st == ST_DATA_ACK) r = send_then(txn_mem_addr[7:0], PH_ADDRL);
                else if (st == ST_DATA_NACK) r = stop_with(OUT_BUSY);
                else r = stop_with(OUT_BUSERR);
            end
            PH_ADDRL: begin
                if (st == ST_DATA_ACK) begin
                    r.action  = txn_read ? ACT_START : ACT_REQ;
                    txn_phase = txn_read ? PH_RSTART : PH_WNEED;
                end else if (st == ST_DATA_NACK) begin
                    r = stop_with(OUT_BUSY);
                end else begin
                    r = stop_with(OUT_BUSERR);
                end
            end
            PH_RSTART: begin
                if (st == ST_REP_START) r = send_then({txn_dev, 1'b1}, PH_SLAR);
                else r = stop_with(OUT_BUSERR);
            end
            PH_SLAR: begin
                if (st == ST_SLAR_ACK) r = issue_read();
                else if (st == ST_SLAR_NACK) r = stop_with(OUT_NODEV);
                else r = stop_with(OUT_BUSERR);
            end
            PH_READ: begin
                // The status of a payload read is not checked; the byte goes out as is.
                txn_done = txn_done + 16'd1;
                if (txn_done >= txn_total) r = stop_with(OUT_OK);
                else r = issue_read();
                r.read_valid = 1'b1;
                r.read_data  = rx;
            end
            PH_WRITE: begin
                if (st == ST_DATA_ACK) begin
                    txn_done = txn_done + 16'd1;
                    if (txn_done >= txn_total) begin
                        r = stop_with(OUT_OK);
                    end else begin
                        r.action  = ACT_REQ;
                        txn_phase = PH_WNEED;
                    end
                end else begin
                    r = stop_with(OUT_BUSY);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Expected result of the beat on the input channel.
    function automatic t_result predict_from_beat();
        t_result r;
        r = '0;
        case (i_mode)
            MODE_CMD: begin
                // A command is only taken while idle.
                if (txn_phase == PH_IDLE) begin
                    txn_dev      = i_dev_addr;
                    txn_read     = i_is_read;
                    txn_wide     = i_addr_two_bytes;
                    txn_mem_addr = i_mem_addr;
                    txn_total    = (i_byte_count == 16'd0) ? 16'd1 : i_byte_count;
                    txn_done     = '0;
                    r.action     = ACT_START;
                    txn_phase    = PH_START;
                end
            end
            MODE_STATUS:  r = on_bus_status(i_bus_status, i_bus_byte);
            MODE_PAYLOAD: begin
                if (txn_phase == PH_WNEED) r = send_then(i_write_byte, PH_WRITE);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Field-by-field comparison of the output beat with the oldest prediction.
    task automatic compare_result(input t_result want);
        if (i_action != want.action)         report_mismatch("action", i_action, want.action);
        if (i_send_byte != want.send_byte)   report_mismatch("send_byte", i_send_byte, want.send_byte);
        if (i_read_valid != want.read_valid) report_mismatch("read_valid", i_read_valid, want.read_valid);
        if (i_read_data != want.read_data)   report_mismatch("read_data", i_read_data, want.read_data);
        if (i_done_res != want.done_res)     report_mismatch("done_res", i_done_res, want.done_res);
        if (i_outcome != want.outcome)       report_mismatch("outcome", i_outcome, want.outcome);
    endtask

    // Watch both channels; a beat accepted at this edge is queued before any pop.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            txn_phase    = PH_IDLE;
            txn_dev      = '0;
            txn_read     = 1'b0;
            txn_wide     = 1'b0;
            txn_mem_addr = '0;
            txn_total    = '0;
            txn_done     = '0;
            owed_results.delete();
            owed_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) owed_results.push_back(predict_from_beat());
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) report_mismatch("beat with nothing owed", 1, 0);
                else compare_result(owed_results.pop_front());
                results_seen++;
            end
            owed_count <= owed_results.size();
        end
    end

endmodule

[dv/tb_i2c_memory_transaction_sequencer.sv]
// Stimulus, clocking and verdict for the I2C memory transaction sequencer.
`timescale 1ns / 1ps

module tb_i2c_memory_transaction_sequencer;
    import i2cmts_pkg::*;

    localparam int         RESET_CYCLES  = 10;
    localparam int         RANDOM_BEATS  = 2000;
    localparam int         LONG_HOLD     = 300;
    localparam int         DRAIN_LIMIT   = 20000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         TIMEOUT_NS    = 3000000;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Everything one input beat carries.
    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  dev_addr;
        logic        is_read;
        logic        two_bytes;
        logic [15:0] mem_addr;
        logic [15:0] byte_count;
        logic [7:0]  bus_status;
        logic [7:0]  bus_byte;
        logic [7:0]  write_byte;
    } t_beat;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_beat       drv       = '0;
    logic        in_ready;
    logic        out_valid;
    logic [2:0]  action;
    logic [7:0]  send_byte;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        done_res;
    logic [1:0]  outcome;
    int          error_count;
    int          results_owed;

    // Stimulus bookkeeping; the hold counters are shared with the receiver process.
    int          beats_sent  = 0;
    int          hold_asks   = 0;
    int          holds_done  = 0;
    bit          burst       = 1'b0;

    always #1 clk = ~clk;

    i2c_memory_transaction_sequencer uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mode           (drv.mode),
        .i_dev_addr       (drv.dev_addr),
        .i_is_read        (drv.is_read),
        .i_addr_two_bytes (drv.two_bytes),
        .i_mem_addr       (drv.mem_addr),
        .i_byte_count     (drv.byte_count),
        .i_bus_status     (drv.bus_status),
        .i_bus_byte       (drv.bus_byte),
        .i_write_byte     (drv.write_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_action         (action),
        .o_send_byte      (send_byte),
        .o_read_valid     (read_valid),
        .o_read_data      (read_data),
        .o_done_res       (done_res),
        .o_outcome        (outcome)
    );

    i2c_memory_transaction_sequencer_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_mode           (drv.mode),
        .i_dev_addr       (drv.dev_addr),
        .i_is_read        (drv.is_read),
        .i_addr_two_bytes (drv.two_bytes),
        .i_mem_addr       (drv.mem_addr),
        .i_byte_count     (drv.byte_count),
        .i_bus_status     (drv.bus_status),
        .i_bus_byte       (drv.bus_byte),
        .i_write_byte     (drv.write_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_action         (action),
        .i_send_byte      (send_byte),
        .i_read_valid     (read_valid),
        .i_read_data      (read_data),
        .i_done_res       (done_res),
        .i_outcome        (outcome),
        .o_error_count    (error_count),
        .o_results_owed   (results_owed)
    );

    // Idle length: mostly none, sometimes a few cycles, rarely a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A beat of the given kind with every field random.
    function automatic t_beat random_beat(logic [1:0] mode);
        t_beat b;
        b.mode       = mode;
        b.dev_addr   = 7'($urandom);
        b.is_read    = 1'($urandom);
        b.two_bytes  = 1'($urandom);
        b.mem_addr   = 16'($urandom);
        b.byte_count = 16'($urandom);
        b.bus_status = 8'($urandom);
        b.bus_byte   = 8'($urandom);
        b.write_byte = 8'($urandom);
        return b;
    endfunction

    // Any code other than the one the sequencer waits for, often the matching nack.
    function automatic logic [7:0] wrong_status(logic [7:0] want);
        logic [7:0] st;
        case (want)
            ST_SLAW_ACK: st = ST_SLAW_NACK;
            ST_DATA_ACK: st = ST_DATA_NACK;
            ST_SLAR_ACK: st = ST_SLAR_NACK;
            default:     st = want;
        endcase
        if ($urandom_range(0, 1) == 0) st = 8'($urandom);
        while (st == want) st = 8'($urandom);
        return st;
    endfunction

    // Offer one beat, hold it until accepted, then idle for a random gap, none in a burst.
    task automatic put_beat(input t_beat b, input bit counted);
        int gap;
        drv      <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (counted) beats_sent++;
        gap = burst ? 0 : idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A beat of any kind but the one the sequencer would act on now.
    task automatic ignored_beat(input logic [1:0] live);
        logic [1:0] m;
        do m = 2'($urandom_range(0, 3)); while (m == live);
        put_beat(random_beat(m), 1'b0);
    endtask

    // Stop offering and wait until every result owed has been taken or the drain limit runs out.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    // One memory transaction as the bus engine would answer it. A wrong code
    // at checked step abort_at ends it; -1 lets it complete.
    task automatic run_transaction(input logic [6:0] dev, input logic rd, input logic wide,
                                   input logic [15:0] maddr, input logic [15:0] count,
                                   input int abort_at, input bit noisy);
        t_beat      b;
        logic [7:0] steps[$];
        int         n;
        int         step;
        n    = (count == 16'd0) ? 1 : int'(count);
        step = 0;
        b            = random_beat(MODE_CMD);
        b.dev_addr   = dev;
        b.is_read    = rd;
        b.two_bytes  = wide;
        b.mem_addr   = maddr;
        b.byte_count = count;
        put_beat(b, 1'b1);

        // Header: start, address with write bit, memory address, and for reads
        // the repeated start and the address with read bit.
        steps.push_back(ST_START);
        steps.push_back(ST_SLAW_ACK);
        if (wide) steps.push_back(ST_DATA_ACK);
        steps.push_back(ST_DATA_ACK);
        if (rd) begin
            steps.push_back(ST_REP_START);
            steps.push_back(ST_SLAR_ACK);
        end
        foreach (steps[k]) begin
            if (noisy && $urandom_range(0, 9) == 0) ignored_beat(MODE_STATUS);
            b = random_beat(MODE_STATUS);
            b.bus_status = (step == abort_at) ? wrong_status(steps[k]) : steps[k];
            put_beat(b, 1'b1);
            if (step == abort_at) return;
            step++;
        end

        // Payload: reads take any status, writes need a byte and then an ack.
        for (int i = 0; i < n; i++) begin
            if (rd) begin
                if (noisy && $urandom_range(0, 9) == 0) ignored_beat(MODE_STATUS);
                put_beat(random_beat(MODE_STATUS), 1'b1);
            end else begin
                if (noisy && $urandom_range(0, 9) == 0) ignored_beat(MODE_PAYLOAD);
                put_beat(random_beat(MODE_PAYLOAD), 1'b1);
                if (noisy && $urandom_range(0, 9) == 0) ignored_beat(MODE_STATUS);
                b = random_beat(MODE_STATUS);
                b.bus_status = (step == abort_at) ? wrong_status(ST_DATA_ACK) : ST_DATA_ACK;
                put_beat(b, 1'b1);
                if (step == abort_at) return;
                step++;
            end
        end
    endtask

    // Random transaction: mostly short counts, a few full-range ones, which are
    // always cut short above 64 bytes so the run stays bounded.
    task automatic random_transaction();
        logic [15:0] count;
        logic        rd;
        logic        wide;
        int          roll;
        int          n;
        int          span;
        int          abort_at;
        rd   = 1'($urandom);
        wide = 1'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 2)       count = 16'd0;
        else if (roll < 62) count = 16'($urandom_range(1, 4));
        else if (roll < 87) count = 16'($urandom_range(5, 16));
        else if (roll < 95) count = 16'($urandom_range(17, 64));
        else                count = 16'($urandom);
        n    = (count == 16'd0) ? 1 : int'(count);
        span = 3 + int'(wide) + (rd ? 2 : ((n < 8) ? n : 8));
        abort_at = -1;
        if (n > 64 || $urandom_range(0, 4) == 0) abort_at = $urandom_range(0, span - 1);
        burst = ($urandom_range(0, 3) == 0);
        run_transaction(7'($urandom), rd, wide, 16'($urandom), count, abort_at, 1'b1);
        burst = 1'b0;
    endtask

    // Receiver: random stalls, long ready stretches, and one long hold on request.
    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_asks != holds_done) begin
                holds_done = hold_asks;
                stall      = LONG_HOLD;
            end else begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 150)) @(posedge clk);
            else repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Sender: directed transactions, a backpressure phase, then random traffic.
    initial begin
        int txn_count;
        txn_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-byte write through a two-byte address; a zero count means one byte.
        run_transaction(7'h7F, 1'b0, 1'b1, 16'hFFFF, 16'h0000, -1, 1'b0);
        // Two-byte read: the first byte is acked, the last one is not.
        run_transaction(7'h00, 1'b1, 1'b0, 16'h0000, 16'd2, -1, 1'b0);
        // Full-range count cut short by a bad start code.
        run_transaction(7'h55, 1'b1, 1'b1, 16'h1234, 16'hFFFF, 0, 1'b0);
        // Status, payload and unused beats while idle are ignored.
        put_beat(random_beat(MODE_STATUS), 1'b0);
        put_beat(random_beat(MODE_PAYLOAD), 1'b0);
        put_beat(random_beat(MODE_UNUSED), 1'b0);
        // Write refused on the memory address.
        run_transaction(7'h2A, 1'b0, 1'b0, 16'h00FF, 16'd3, 2, 1'b0);
        wait_for_results();

        // Receiver holds off while the sender keeps offering back to back.
        hold_asks++;
        wait (holds_done == hold_asks);
        burst = 1'b1;
        run_transaction(7'h3C, 1'b0, 1'b1, 16'hA55A, 16'd6, -1, 1'b0);
        burst = 1'b0;
        wait_for_results();

        // Random traffic with occasional idle noise and full drains.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 7) == 0) ignored_beat(MODE_CMD);
            random_transaction();
            txn_count++;
            if (txn_count % 60 == 0) wait_for_results();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (results_owed != 0) $display("ERROR %0d expected results never arrived", results_owed);
        if (error_count == 0 && results_owed == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("ERROR timeout, %0d results still owed", results_owed);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/i2cmts_pkg.sv
hw/rtl/i2cmts_core.sv
hw/rtl/i2c_memory_transaction_sequencer.sv
dv/i2c_memory_transaction_sequencer_checker.sv
dv/tb_i2c_memory_transaction_sequencer.sv
